// ===== hw/rtl/lab_pkg.sv =====
package lab_pkg;

   localparam int unsigned CH_W = 16;          // input channel width
   localparam int unsigned T_W = 17;           // Q16 tristimulus, 65536 = 1.0
   localparam int unsigned ROOT_STAGES = T_W;  // one root bit per stage
   localparam int unsigned L_W = 15;
   localparam int unsigned AB_W = 16;
   localparam int unsigned LIN_L_W = 11;

   // matrix rows with the white point folded in, Q16 over full scale
   localparam logic [15:0] KX_R = 16'd28440;
   localparam logic [15:0] KX_G = 16'd24656;
   localparam logic [15:0] KX_B = 16'd12441;
   localparam logic [15:0] KY_R = 16'd13938;
   localparam logic [15:0] KY_G = 16'd46869;
   localparam logic [15:0] KY_B = 16'd4730;
   localparam logic [15:0] KZ_R = 16'd1164;
   localparam logic [15:0] KZ_G = 16'd7174;
   localparam logic [15:0] KZ_B = 16'd57193;

   localparam logic [T_W-1:0] KNEE = 17'd580;
   localparam logic [18:0] SLOPE = 19'd510329;
   localparam logic [T_W-1:0] OFFSET = 17'd9039;
   localparam logic [17:0] LIN_L = 18'd231245;
   localparam int signed L_MAX = 25600;

   typedef struct packed {
      logic [2:0][T_W-1:0] lin_f;   // linear segment of f for x, y, z
      logic [2:0] above;            // t above the knee, per channel
      logic [LIN_L_W-1:0] light_lin;
   } side_type;

endpackage

// ===== hw/rtl/lab_matrix.sv =====
module lab_matrix (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic [lab_pkg::CH_W-1:0] red,
   input  logic [lab_pkg::CH_W-1:0] green,
   input  logic [lab_pkg::CH_W-1:0] blue,
   output logic valid_out,
   output logic [2:0][lab_pkg::T_W-1:0] t_out
);

   logic [2:0][2:0][31:0] prod_ff;
   logic [2:0][31:0] prod_in [3];
   logic [2:0][lab_pkg::T_W-1:0] t_ff;
   logic [2:0][lab_pkg::T_W-1:0] t_in;
   logic [1:0] valid_ff;

   always_comb begin
      prod_in[0][0] = 32'(lab_pkg::KX_R) * 32'(red);
      prod_in[0][1] = 32'(lab_pkg::KX_G) * 32'(green);
      prod_in[0][2] = 32'(lab_pkg::KX_B) * 32'(blue);
      prod_in[1][0] = 32'(lab_pkg::KY_R) * 32'(red);
      prod_in[1][1] = 32'(lab_pkg::KY_G) * 32'(green);
      prod_in[1][2] = 32'(lab_pkg::KY_B) * 32'(blue);
      prod_in[2][0] = 32'(lab_pkg::KZ_R) * 32'(red);
      prod_in[2][1] = 32'(lab_pkg::KZ_G) * 32'(green);
      prod_in[2][2] = 32'(lab_pkg::KZ_B) * 32'(blue);
   end

   always_comb begin
      logic [33:0] sum;
      for (int i = 0; i < 3; i++) begin
         sum = 34'(prod_ff[i][0]) + 34'(prod_ff[i][1]) + 34'(prod_ff[i][2]) + 34'd32768;
         t_in[i] = sum[16 +: lab_pkg::T_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      t_ff <= t_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[0], valid_in};
      end
   end

   assign valid_out = valid_ff[1];
   assign t_out = t_ff;

endmodule

// ===== hw/rtl/lab_cbrt.sv =====
module lab_cbrt (
   input  logic clock,
   input  logic [lab_pkg::T_W-1:0] t_in,
   output logic [lab_pkg::T_W-1:0] root
);

   localparam int unsigned N = lab_pkg::ROOT_STAGES;

   logic [lab_pkg::T_W-1:0] t_ff [N];
   logic [lab_pkg::T_W-1:0] f_ff [N];
   logic [35:0] f2_ff [N];
   logic [51:0] f3_ff [N];

   // restoring cube root, one result bit per stage; square and cube kept running
   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam int K = N - 1 - i;
      logic [lab_pkg::T_W-1:0] t_src;
      logic [lab_pkg::T_W-1:0] f_src;
      logic [35:0] f2_src;
      logic [51:0] f3_src;
      logic [lab_pkg::T_W-1:0] c;
      logic [35:0] c2;
      logic [51:0] c3;
      logic hit;

      if (i == 0) begin : g_first
         assign t_src = t_in;
         assign f_src = '0;
         assign f2_src = '0;
         assign f3_src = '0;
      end else begin : g_next
         assign t_src = t_ff[i-1];
         assign f_src = f_ff[i-1];
         assign f2_src = f2_ff[i-1];
         assign f3_src = f3_ff[i-1];
      end

      assign c = f_src | (lab_pkg::T_W'(1) << K);
      assign c2 = f2_src + (36'(f_src) << (K + 1)) + (36'(1) << (2 * K));
      assign c3 = f3_src + ((52'(f2_src) * 52'd3) << K)
                  + ((52'(f_src) * 52'd3) << (2 * K)) + (52'(1) << (3 * K));
      assign hit = c3 <= {3'b000, t_src, 32'b0};

      always_ff @(posedge clock) begin
         t_ff[i] <= t_src;
         if (hit) begin
            f_ff[i] <= c;
            f2_ff[i] <= c2;
            f3_ff[i] <= c3;
         end else begin
            f_ff[i] <= f_src;
            f2_ff[i] <= f2_src;
            f3_ff[i] <= f3_src;
         end
      end
   end

   assign root = f_ff[N-1];

endmodule

// ===== hw/rtl/rgb_to_cielab_convert.sv =====
// Linear RGB to CIELAB (D65 white), fixed point, fully pipelined.
// Request channel: req_red/green/blue are taken at a rising edge with start
// high; busy is always low, so a request may be issued every cycle.
// Result channel: rsp_lightness (L, 8 fraction bits), rsp_green_red_axis (a)
// and rsp_blue_yellow_axis (b, both signed, 8 fraction bits, saturated) are
// shown for one cycle with rsp_strobe high.
// A request passes the matrix, then the bit-per-stage cube root, then the
// final scale and saturation, before its strobe.
// Throughput is one pixel per cycle; every stage carries its own valid bit.
// Results appear in request order, one per request.
// Reset clears all valid bits; requests in flight are dropped and no strobe
// follows until new requests arrive.
// The receiver has no way to stall: it must take each result in the cycle
// its strobe is high.
module rgb_to_cielab_convert (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [lab_pkg::CH_W-1:0] req_red,
   input  logic [lab_pkg::CH_W-1:0] req_green,
   input  logic [lab_pkg::CH_W-1:0] req_blue,
   output logic rsp_strobe,
   output logic [lab_pkg::L_W-1:0] rsp_lightness,
   output logic signed [lab_pkg::AB_W-1:0] rsp_green_red_axis,
   output logic signed [lab_pkg::AB_W-1:0] rsp_blue_yellow_axis
);

   localparam int unsigned N = lab_pkg::ROOT_STAGES;

   logic mat_valid;
   logic [2:0][lab_pkg::T_W-1:0] t;
   logic [2:0][lab_pkg::T_W-1:0] root;
   lab_pkg::side_type side_in;
   lab_pkg::side_type side_ff [N];
   logic [N-1:0] valid_ff;

   assign busy = 1'b0;

   lab_matrix u_matrix (
      .clock(clock),
      .reset(reset),
      .valid_in(start),
      .red(req_red),
      .green(req_green),
      .blue(req_blue),
      .valid_out(mat_valid),
      .t_out(t)
   );

   for (genvar c = 0; c < 3; c++) begin : g_root
      lab_cbrt u_cbrt (
         .clock(clock),
         .t_in(t[c]),
         .root(root[c])
      );
   end

   always_comb begin
      logic [35:0] lin;
      logic [35:0] ll;
      for (int c = 0; c < 3; c++) begin
         lin = 36'(lab_pkg::SLOPE) * 36'(t[c]) + 36'd32768;
         side_in.lin_f[c] = lin[16 +: lab_pkg::T_W] + lab_pkg::OFFSET;
         side_in.above[c] = t[c] > lab_pkg::KNEE;
      end
      ll = 36'(lab_pkg::LIN_L) * 36'(t[1]) + 36'd32768;
      side_in.light_lin = ll[16 +: lab_pkg::LIN_L_W];
   end

   // side data runs beside the root stages
   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < N; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[N-2:0], mat_valid};
      end
   end

   // final stage one: pick f, scale
   logic [2:0][lab_pkg::T_W-1:0] f;
   logic signed [17:0] light_in;
   logic signed [27:0] a_in;
   logic signed [27:0] b_in;
   logic signed [17:0] light_ff;
   logic signed [27:0] a_ff;
   logic signed [27:0] b_ff;
   logic fin_valid_ff;

   always_comb begin
      logic [23:0] ly;
      for (int c = 0; c < 3; c++) begin
         f[c] = side_ff[N-1].above[c] ? root[c] : side_ff[N-1].lin_f[c];
      end
      ly = 24'd116 * 24'(f[1]) + 24'd128;
      if (side_ff[N-1].above[1]) begin
         light_in = 18'(signed'({2'b00, ly[23:8]})) - 18'sd4096;
      end else begin
         light_in = 18'(signed'({1'b0, side_ff[N-1].light_lin}));
      end
      a_in = 28'sd500 * (28'(signed'({1'b0, f[0]})) - 28'(signed'({1'b0, f[1]})));
      b_in = 28'sd200 * (28'(signed'({1'b0, f[1]})) - 28'(signed'({1'b0, f[2]})));
   end

   // final stage two: round half up, clamp
   function automatic logic [lab_pkg::AB_W-1:0] sat16(input logic signed [27:0] v);
      logic signed [27:0] r;
      logic signed [19:0] q;
      r = v + 28'sd128;
      q = 20'(r >>> 8);
      if (q > 20'sd32767) begin
         return 16'h7FFF;
      end else if (q < -20'sd32768) begin
         return 16'h8000;
      end
      return q[15:0];
   endfunction

   logic [lab_pkg::L_W-1:0] light_sat;

   always_comb begin
      if (light_ff < 18'sd0) begin
         light_sat = '0;
      end else if (light_ff > 18'(lab_pkg::L_MAX)) begin
         light_sat = lab_pkg::L_W'(lab_pkg::L_MAX);
      end else begin
         light_sat = light_ff[lab_pkg::L_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      light_ff <= light_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rsp_lightness <= light_sat;
      rsp_green_red_axis <= sat16(a_ff);
      rsp_blue_yellow_axis <= sat16(b_ff);
      if (reset) begin
         fin_valid_ff <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         fin_valid_ff <= valid_ff[N-1];
         rsp_strobe <= fin_valid_ff;
      end
   end

endmodule

// ===== tb/sv/rgb_to_cielab_convert_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_cielab_convert_tb;

   typedef struct {
      logic [lab_pkg::L_W-1:0] lightness;
      logic signed [lab_pkg::AB_W-1:0] a_axis;
      logic signed [lab_pkg::AB_W-1:0] b_axis;
   } lab_pixel_type;

   class lab_scoreboard;
      lab_pixel_type expected_lab[$];
      int errors;
      int checked;

      function longint unsigned tristim(longint unsigned r, longint unsigned g,
                                        longint unsigned b, longint unsigned kr,
                                        longint unsigned kg, longint unsigned kb);
         return (kr * r + kg * g + kb * b + 32768) >> 16;
      endfunction

      function longint unsigned lab_curve(longint unsigned t);
         longint unsigned target, f, c;
         if (t > lab_pkg::KNEE) begin
            target = t << 32;
            f = 0;
            for (int i = 16; i >= 0; i--) begin
               c = f | (64'd1 << i);
               if (c * c * c <= target)
                  f = c;
            end
            return f;
         end
         return ((lab_pkg::SLOPE * t + 32768) >> 16) + lab_pkg::OFFSET;
      endfunction

      // round half up by 256, then clamp to 16 bits signed
      function logic signed [lab_pkg::AB_W-1:0] scale_clamp(longint v);
         longint q;
         q = (v + 128) >>> 8;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[lab_pkg::AB_W-1:0];
      endfunction

      function lab_pixel_type predict_lab(logic [15:0] r, logic [15:0] g, logic [15:0] b);
         lab_pixel_type p;
         longint unsigned xr, yr, zr;
         longint fx, fy, fz, light;
         xr = tristim(r, g, b, lab_pkg::KX_R, lab_pkg::KX_G, lab_pkg::KX_B);
         yr = tristim(r, g, b, lab_pkg::KY_R, lab_pkg::KY_G, lab_pkg::KY_B);
         zr = tristim(r, g, b, lab_pkg::KZ_R, lab_pkg::KZ_G, lab_pkg::KZ_B);
         fx = lab_curve(xr);
         fy = lab_curve(yr);
         fz = lab_curve(zr);
         if (yr > lab_pkg::KNEE)
            light = longint'((116 * fy + 128) >> 8) - 4096;
         else
            light = longint'((lab_pkg::LIN_L * yr + 32768) >> 16);
         if (light < 0) light = 0;
         if (light > lab_pkg::L_MAX) light = lab_pkg::L_MAX;
         p.lightness = light[lab_pkg::L_W-1:0];
         p.a_axis = scale_clamp(500 * (fx - fy));
         p.b_axis = scale_clamp(200 * (fy - fz));
         return p;
      endfunction

      function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
         expected_lab.push_back(predict_lab(r, g, b));
      endfunction

      function void check_pixel(logic [lab_pkg::L_W-1:0] l,
                                logic signed [lab_pkg::AB_W-1:0] a,
                                logic signed [lab_pkg::AB_W-1:0] b);
         lab_pixel_type e;
         if (expected_lab.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
         end
         e = expected_lab.pop_front();
         checked++;
         if (l !== e.lightness) begin
            $error("lightness: expected %0d, got %0d", e.lightness, l);
            errors++;
         end
         if (a !== e.a_axis) begin
            $error("green_red_axis: expected %0d, got %0d", e.a_axis, a);
            errors++;
         end
         if (b !== e.b_axis) begin
            $error("blue_yellow_axis: expected %0d, got %0d", e.b_axis, b);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [lab_pkg::CH_W-1:0] req_red = '0, req_green = '0, req_blue = '0;
   logic rsp_strobe;
   logic [lab_pkg::L_W-1:0] rsp_lightness;
   logic signed [lab_pkg::AB_W-1:0] rsp_green_red_axis, rsp_blue_yellow_axis;

   lab_scoreboard sb = new();
   int cycles = 0;
   int sent = 0;
   bit eager = 0;

   rgb_to_cielab_convert dut (
      .clock, .reset, .start, .busy, .req_red, .req_green, .req_blue,
      .rsp_strobe, .rsp_lightness, .rsp_green_red_axis, .rsp_blue_yellow_axis
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (!reset && start && !busy) begin
         sb.note_pixel(req_red, req_green, req_blue);
         sent++;
      end
      if (!reset && rsp_strobe)
         sb.check_pixel(rsp_lightness, rsp_green_red_axis, rsp_blue_yellow_axis);
      if (cycles > 200000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one request; start stays high across back-to-back requests
   task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      int gap;
      gap = eager ? 0 : int'($urandom_range(0, 3));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [15:0] draw_channel();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 1200));   // around the knee
         1: return 16'(1) << $urandom_range(0, 15);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pixel(16'd0, 16'd0, 16'd0);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'd0, 16'd0);
      send_pixel(16'd0, 16'hFFFF, 16'd0);
      send_pixel(16'd0, 16'd0, 16'hFFFF);
      send_pixel(16'hFFFF, 16'hFFFF, 16'd0);
      send_pixel(16'd0, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'd0, 16'hFFFF);
      // yr either side of the knee
      send_pixel(16'd0, 16'd810, 16'd0);
      send_pixel(16'd0, 16'd811, 16'd0);
      send_pixel(16'd0, 16'd812, 16'd0);
      send_pixel(16'd810, 16'd810, 16'd810);
      send_pixel(16'd811, 16'd811, 16'd811);
      send_pixel(16'd1, 16'd1, 16'd1);
      send_pixel(16'd0, 16'd0, 16'd1);
      send_pixel(16'hFFFF, 16'd0, 16'd1);
      send_pixel(16'd0, 16'd1, 16'hFFFF);
      for (int i = 0; i < 950; i++) begin
         if (i % 100 == 0) eager = ($urandom_range(0, 2) == 0);
         send_pixel(draw_channel(), draw_channel(), draw_channel());
      end
      start <= 1'b0;
      while (sb.expected_lab.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Converted %0d pixels, %0d results checked, %0d mismatches.",
               sent, sb.checked, sb.errors);
      $display("Covered black, white, primaries, knee edges and random pixels.");
      if (sb.errors == 0 && sb.expected_lab.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/lab_pkg.sv
hw/rtl/lab_matrix.sv
hw/rtl/lab_cbrt.sv
hw/rtl/rgb_to_cielab_convert.sv
tb/sv/rgb_to_cielab_convert_tb.sv
